// ===== rtl/vfpe_pkg.sv =====
package vfpe_pkg;

    localparam int HANDLE_W    = 16;
    localparam int FBITS_W     = 14;
    localparam int VID_W       = 12;
    localparam int PCP_W       = 3;
    localparam int CLS_W       = 3;
    localparam int MAX_CLASSES = 8;
    localparam int RATE_W      = 7;
    localparam int CNT_W       = 3;
    localparam int MAX_VLANS   = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;
    localparam int TOTAL_OUT_W = 8;

    localparam logic [FBITS_W-1:0] IFG_BITS = FBITS_W'(96);
    localparam logic [RATE_W-1:0]  RATE_MAX = RATE_W'(64);

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_FRAME = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_BITS_PER_TICK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VLAN_A        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VLAN_B        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VLAN_C        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VLAN_D        = 3'd5;

    typedef enum logic [2:0] {
        EV_TICK       = 3'd0,
        EV_QUEUED     = 3'd1,
        EV_VLAN_DENY  = 3'd2,
        EV_NO_TAG     = 3'd3,
        EV_CLASS_FULL = 3'd4
    } ev_t;

    typedef enum logic [1:0] {
        LINK_IDLE = 2'd0,
        LINK_TX   = 2'd1,
        LINK_IFG  = 2'd2
    } link_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_READ,
        SEQ_LOAD
    } seq_t;

    typedef logic [MAX_VLANS-1:0][VID_W-1:0] vlan_list_t;

    typedef struct packed {
        logic [VID_W-1:0]    vid;
        logic [FBITS_W-1:0]  fbits;
        logic [HANDLE_W-1:0] handle;
    } desc_t;

    typedef struct packed {
        logic pass;
        ev_t  code;
    } filt_t;

    typedef struct packed {
        logic             enq;
        logic             bypass;
        logic             deq;
        logic [CLS_W-1:0] cls;
        desc_t            desc;
    } q_req_t;

    typedef struct packed {
        logic [MAX_CLASSES-1:0] full;
        logic                   any;
        logic [CLS_W-1:0]       top;
    } q_stat_t;

endpackage

// ===== rtl/vlan_filtered_priority_egress.sv =====
// Egress port with an 802.1Q VLAN filter and a strict priority scheduler. Each input word
// is a tick (command 0) or a frame descriptor (command 1) and gives exactly one result word.
// A result word is registered: the accepting edge moves the sequencer to its load state, which
// fills the result register. A tick that ends an inter-frame gap and launches a waiting frame
// passes through a read state first, because the descriptor is read from the shared descriptor
// memory, whose read data is registered. The next word is accepted at the earliest at the edge
// that takes the result word, so a word holds the block until its result is loaded and taken,
// and longer while the receiver holds off. Descriptors of all classes live in one memory of
// NUM_CLASSES * CLASS_DEPTH entries; head, tail and fill counts per class sit in flops. There
// is no clearing pass after reset. Configuration writes are always taken (ready high).
module vlan_filtered_priority_egress #(
    parameter int CLASS_DEPTH = 16,
    parameter int NUM_CLASSES = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [vfpe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vfpe_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                command,
    input  logic [vfpe_pkg::HANDLE_W-1:0]       frame_handle,
    input  logic [vfpe_pkg::FBITS_W-1:0]        frame_bits,
    input  logic                                tagged_req,
    input  logic [vfpe_pkg::VID_W-1:0]          vid,
    input  logic [vfpe_pkg::PCP_W-1:0]          priority_code,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [2:0]                          event_res,
    output logic                                tx_start,
    output logic [vfpe_pkg::HANDLE_W-1:0]       tx_handle,
    output logic [vfpe_pkg::FBITS_W-1:0]        tx_bits,
    output logic [vfpe_pkg::CLS_W-1:0]          tx_priority,
    output logic [vfpe_pkg::VID_W-1:0]          tx_vid,
    output logic [vfpe_pkg::TOTAL_OUT_W-1:0]    queued_total,
    output logic [1:0]                          link_mode
);

    localparam int TOT_W = $clog2(NUM_CLASSES * CLASS_DEPTH + 1);

    // configuration
    logic [vfpe_pkg::RATE_W-1:0] bpt_reg;
    logic [vfpe_pkg::CNT_W-1:0]  count_reg;
    vfpe_pkg::vlan_list_t        vlan_reg;

    // control
    vfpe_pkg::seq_t              seq_reg, seq_next;
    vfpe_pkg::link_t             mode_reg, mode_next;
    logic [vfpe_pkg::FBITS_W-1:0] bits_left_reg, bits_left_next;
    logic                        out_valid_reg, out_valid_next;

    // pending result
    vfpe_pkg::ev_t               ev_reg, ev_next;
    logic                        start_reg, start_next;
    vfpe_pkg::desc_t             txd_reg, txd_next;
    logic [vfpe_pkg::CLS_W-1:0]  txc_reg, txc_next;

    // result register
    vfpe_pkg::ev_t               out_ev_reg, out_ev_next;
    logic                        out_start_reg, out_start_next;
    vfpe_pkg::desc_t             out_txd_reg, out_txd_next;
    logic [vfpe_pkg::CLS_W-1:0]  out_txc_reg, out_txc_next;
    logic [TOT_W-1:0]            out_total_reg, out_total_next;
    vfpe_pkg::link_t             out_mode_reg, out_mode_next;

    vfpe_pkg::filt_t             verdict;
    vfpe_pkg::q_req_t            req;
    vfpe_pkg::q_stat_t           stat;
    vfpe_pkg::desc_t             rd_data;
    logic [TOT_W-1:0]            total;

    logic                        accept;
    logic [vfpe_pkg::RATE_W-1:0] rate;
    logic [vfpe_pkg::CLS_W-1:0]  cls;
    vfpe_pkg::desc_t             in_desc;
    logic                        rate_done;

    vfpe_vlan_filter u_filter (
        .tagged_req    (tagged_req),
        .vid           (vid),
        .allowed_count (count_reg),
        .allowed_list  (vlan_reg),
        .verdict       (verdict)
    );

    vfpe_class_queues #(
        .CLASS_DEPTH (CLASS_DEPTH),
        .NUM_CLASSES (NUM_CLASSES)
    ) u_queues (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .stat    (stat),
        .rd_data (rd_data),
        .total   (total)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpt_reg   <= vfpe_pkg::RATE_W'(1);
            count_reg <= '0;
            vlan_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                vfpe_pkg::CFG_BITS_PER_TICK: bpt_reg <= cfg_data[vfpe_pkg::RATE_W-1:0];
                vfpe_pkg::CFG_ALLOWED_COUNT: count_reg <= cfg_data[vfpe_pkg::CNT_W-1:0];
                vfpe_pkg::CFG_VLAN_A:        vlan_reg[0] <= cfg_data;
                vfpe_pkg::CFG_VLAN_B:        vlan_reg[1] <= cfg_data;
                vfpe_pkg::CFG_VLAN_C:        vlan_reg[2] <= cfg_data;
                vfpe_pkg::CFG_VLAN_D:        vlan_reg[3] <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (bpt_reg == '0)
        begin
            rate = vfpe_pkg::RATE_W'(1);
        end
        else if (bpt_reg > vfpe_pkg::RATE_MAX)
        begin
            rate = vfpe_pkg::RATE_MAX;
        end
        else
        begin
            rate = bpt_reg;
        end
    end

    assign rate_done = (bits_left_reg <= vfpe_pkg::FBITS_W'(rate));
    assign cls = (priority_code >= vfpe_pkg::CLS_W'(NUM_CLASSES - 1))
                 ? vfpe_pkg::CLS_W'(NUM_CLASSES - 1) : priority_code;
    assign in_desc = '{vid: vid, fbits: frame_bits, handle: frame_handle};
    assign in_ready = (seq_reg == vfpe_pkg::SEQ_IDLE) && (!out_valid_reg || out_ready);
    assign accept = in_valid && in_ready;

    always_comb
    begin
        seq_next       = seq_reg;
        mode_next      = mode_reg;
        bits_left_next = bits_left_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ev_next        = ev_reg;
        start_next     = start_reg;
        txd_next       = txd_reg;
        txc_next       = txc_reg;
        out_ev_next    = out_ev_reg;
        out_start_next = out_start_reg;
        out_txd_next   = out_txd_reg;
        out_txc_next   = out_txc_reg;
        out_total_next = out_total_reg;
        out_mode_next  = out_mode_reg;
        req            = '0;
        req.cls        = cls;
        req.desc       = in_desc;

        unique case (seq_reg)
            vfpe_pkg::SEQ_IDLE:
            begin
                if (accept)
                begin
                    seq_next   = vfpe_pkg::SEQ_LOAD;
                    start_next = 1'b0;
                    txd_next   = '0;
                    txc_next   = '0;
                    if (command == vfpe_pkg::CMD_TICK)
                    begin
                        ev_next = vfpe_pkg::EV_TICK;
                        case (mode_reg)
                            vfpe_pkg::LINK_TX:
                            begin
                                if (rate_done)
                                begin
                                    mode_next      = vfpe_pkg::LINK_IFG;
                                    bits_left_next = vfpe_pkg::IFG_BITS;
                                end
                                else
                                begin
                                    bits_left_next = bits_left_reg - vfpe_pkg::FBITS_W'(rate);
                                end
                            end
                            vfpe_pkg::LINK_IFG:
                            begin
                                if (!rate_done)
                                begin
                                    bits_left_next = bits_left_reg - vfpe_pkg::FBITS_W'(rate);
                                end
                                else if (stat.any)
                                begin
                                    // descriptor comes back from memory next cycle
                                    req.deq    = 1'b1;
                                    mode_next  = vfpe_pkg::LINK_TX;
                                    seq_next   = vfpe_pkg::SEQ_READ;
                                    start_next = 1'b1;
                                    txc_next   = stat.top;
                                end
                                else
                                begin
                                    mode_next      = vfpe_pkg::LINK_IDLE;
                                    bits_left_next = '0;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    else if (!verdict.pass)
                    begin
                        ev_next = verdict.code;
                    end
                    else if (stat.full[cls])
                    begin
                        ev_next = vfpe_pkg::EV_CLASS_FULL;
                    end
                    else
                    begin
                        ev_next = vfpe_pkg::EV_QUEUED;
                        req.enq = 1'b1;
                        if (mode_reg == vfpe_pkg::LINK_IDLE)
                        begin
                            // link idle means every class is empty: send this one straight on
                            req.bypass     = 1'b1;
                            start_next     = 1'b1;
                            txd_next       = in_desc;
                            txc_next       = cls;
                            mode_next      = vfpe_pkg::LINK_TX;
                            bits_left_next = frame_bits;
                        end
                    end
                end
            end
            vfpe_pkg::SEQ_READ:
            begin
                txd_next       = rd_data;
                bits_left_next = rd_data.fbits;
                seq_next       = vfpe_pkg::SEQ_LOAD;
            end
            vfpe_pkg::SEQ_LOAD:
            begin
                out_valid_next = 1'b1;
                out_ev_next    = ev_reg;
                out_start_next = start_reg;
                out_txd_next   = txd_reg;
                out_txc_next   = txc_reg;
                out_total_next = total;
                out_mode_next  = mode_reg;
                seq_next       = vfpe_pkg::SEQ_IDLE;
            end
            default:
            begin
                seq_next = vfpe_pkg::SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= vfpe_pkg::SEQ_IDLE;
            mode_reg      <= vfpe_pkg::LINK_IDLE;
            bits_left_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg       <= seq_next;
            mode_reg      <= mode_next;
            bits_left_reg <= bits_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_reg        <= ev_next;
        start_reg     <= start_next;
        txd_reg       <= txd_next;
        txc_reg       <= txc_next;
        out_ev_reg    <= out_ev_next;
        out_start_reg <= out_start_next;
        out_txd_reg   <= out_txd_next;
        out_txc_reg   <= out_txc_next;
        out_total_reg <= out_total_next;
        out_mode_reg  <= out_mode_next;
    end

    assign out_valid    = out_valid_reg;
    assign event_res    = out_ev_reg;
    assign tx_start     = out_start_reg;
    assign tx_handle    = out_txd_reg.handle;
    assign tx_bits      = out_txd_reg.fbits;
    assign tx_priority  = out_txc_reg;
    assign tx_vid       = out_txd_reg.vid;
    assign queued_total = vfpe_pkg::TOTAL_OUT_W'(out_total_reg);
    assign link_mode    = out_mode_reg;

    a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg == vfpe_pkg::SEQ_LOAD |-> !out_valid_reg)
        else $error("result register still occupied when loading");

    a_deq_then_read: assert property (@(posedge clk) disable iff (!rst_n)
        req.deq |=> seq_reg == vfpe_pkg::SEQ_READ && mode_reg == vfpe_pkg::LINK_TX)
        else $error("dequeue not followed by memory read phase");

    a_idle_means_empty: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == vfpe_pkg::LINK_IDLE |-> total == '0 && !stat.any)
        else $error("link idle while frames wait");

    a_no_enq_and_deq: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.enq && req.deq))
        else $error("enqueue and dequeue in the same cycle");

endmodule

// ===== rtl/vfpe_vlan_filter.sv =====
module vfpe_vlan_filter (
    input  logic                           tagged_req,
    input  logic [vfpe_pkg::VID_W-1:0]     vid,
    input  logic [vfpe_pkg::CNT_W-1:0]     allowed_count,
    input  vfpe_pkg::vlan_list_t           allowed_list,
    output vfpe_pkg::filt_t                verdict
);

    logic [vfpe_pkg::CNT_W-1:0] n;
    logic                       hit;

    always_comb
    begin
        n = (allowed_count > vfpe_pkg::CNT_W'(vfpe_pkg::MAX_VLANS))
            ? vfpe_pkg::CNT_W'(vfpe_pkg::MAX_VLANS) : allowed_count;
        hit = 1'b0;
        for (int i = 0; i < vfpe_pkg::MAX_VLANS; i++)
        begin
            if ((vfpe_pkg::CNT_W'(i) < n) && (allowed_list[i] == vid))
            begin
                hit = 1'b1;
            end
        end
        // empty list is checked before the tag
        if ((n == '0) || !tagged_req)
        begin
            verdict.pass = 1'b0;
            verdict.code = vfpe_pkg::EV_NO_TAG;
        end
        else if (!hit)
        begin
            verdict.pass = 1'b0;
            verdict.code = vfpe_pkg::EV_VLAN_DENY;
        end
        else
        begin
            verdict.pass = 1'b1;
            verdict.code = vfpe_pkg::EV_QUEUED;
        end
    end

endmodule

// ===== rtl/vfpe_class_queues.sv =====
module vfpe_class_queues #(
    parameter int CLASS_DEPTH = 16,
    parameter int NUM_CLASSES = 8,
    localparam int DEPTH_ALL  = NUM_CLASSES * CLASS_DEPTH,
    localparam int TOT_W      = $clog2(DEPTH_ALL + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  vfpe_pkg::q_req_t     req,
    output vfpe_pkg::q_stat_t    stat,
    output vfpe_pkg::desc_t      rd_data,
    output logic [TOT_W-1:0]     total
);

    localparam int PTR_W  = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
    localparam int FILL_W = $clog2(CLASS_DEPTH + 1);
    localparam int CIDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int ADDR_W = (DEPTH_ALL > 1) ? $clog2(DEPTH_ALL) : 1;

    logic [PTR_W-1:0]  head_reg [NUM_CLASSES];
    logic [PTR_W-1:0]  tail_reg [NUM_CLASSES];
    logic [FILL_W-1:0] fill_reg [NUM_CLASSES];
    logic [TOT_W-1:0]  total_reg;

    vfpe_pkg::desc_t   mem [DEPTH_ALL];
    vfpe_pkg::desc_t   rd_data_reg;

    logic [CIDX_W-1:0] enq_cidx;
    logic [CIDX_W-1:0] deq_cidx;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(CLASS_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign enq_cidx = req.cls[CIDX_W-1:0];
    assign deq_cidx = stat.top[CIDX_W-1:0];
    assign wr_addr  = ADDR_W'(enq_cidx) * ADDR_W'(CLASS_DEPTH) + ADDR_W'(tail_reg[enq_cidx]);
    assign rd_addr  = ADDR_W'(deq_cidx) * ADDR_W'(CLASS_DEPTH) + ADDR_W'(head_reg[deq_cidx]);

    // strict priority: highest non-empty class wins
    always_comb
    begin
        stat.full = '0;
        stat.any  = 1'b0;
        stat.top  = '0;
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            stat.full[c] = (fill_reg[c] == FILL_W'(CLASS_DEPTH));
            if (fill_reg[c] != '0)
            begin
                stat.any = 1'b1;
                stat.top = vfpe_pkg::CLS_W'(c);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                head_reg[c] <= '0;
                tail_reg[c] <= '0;
                fill_reg[c] <= '0;
            end
            total_reg <= '0;
        end
        else
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                if (req.enq && (CIDX_W'(c) == enq_cidx))
                begin
                    tail_reg[c] <= ptr_inc(tail_reg[c]);
                    // a bypassed word leaves at once, fill stays
                    if (req.bypass)
                    begin
                        head_reg[c] <= ptr_inc(head_reg[c]);
                    end
                    else
                    begin
                        fill_reg[c] <= fill_reg[c] + FILL_W'(1);
                    end
                end
                if (req.deq && (CIDX_W'(c) == deq_cidx))
                begin
                    head_reg[c] <= ptr_inc(head_reg[c]);
                    fill_reg[c] <= fill_reg[c] - FILL_W'(1);
                end
            end
            if (req.enq && !req.bypass)
            begin
                total_reg <= total_reg + TOT_W'(1);
            end
            else if (req.deq)
            begin
                total_reg <= total_reg - TOT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.enq)
        begin
            mem[wr_addr] <= req.desc;
        end
        if (req.deq)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign total   = total_reg;

endmodule

// ===== tb/vlan_filtered_priority_egress_tb.sv =====
`timescale 1ns / 1ps

module vlan_filtered_priority_egress_tb;

    localparam int CLASS_DEPTH     = 16;
    localparam int NUM_CLASSES     = 8;
    localparam int NUM_PHASES      = 8;
    localparam int WORDS_PER_PHASE = 20;
    localparam int BURST_WORDS     = 18;
    localparam int SETTLE_CYCLES   = 6;
    localparam int HOLD_CYCLES     = 300;
    localparam int STALL_LIMIT     = 4000;
    localparam int PRESSURE_PHASE  = 4;
    localparam int RESET_ROWS      = 2;
    localparam int DRAIN_RATE      = 64;

    typedef struct packed {
        logic                          cmd;
        logic [vfpe_pkg::HANDLE_W-1:0] handle;
        logic [vfpe_pkg::FBITS_W-1:0]  fbits;
        logic                          tag_on;
        logic [vfpe_pkg::VID_W-1:0]    vid;
        logic [vfpe_pkg::PCP_W-1:0]    pcp;
    } egress_word_t;

    typedef struct packed {
        vfpe_pkg::ev_t                    ev;
        logic                             start;
        logic [vfpe_pkg::HANDLE_W-1:0]    handle;
        logic [vfpe_pkg::FBITS_W-1:0]     fbits;
        logic [vfpe_pkg::CLS_W-1:0]       pri;
        logic [vfpe_pkg::VID_W-1:0]       vid;
        logic [vfpe_pkg::TOTAL_OUT_W-1:0] total;
        vfpe_pkg::link_t                  link;
    } egress_res_t;

    typedef struct {
        egress_word_t w;
        bit           known;
        egress_res_t  res;
    } dir_row_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [vfpe_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [vfpe_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                             in_valid = 1'b0;
    logic                             in_ready;
    logic                             command = vfpe_pkg::CMD_TICK;
    logic [vfpe_pkg::HANDLE_W-1:0]    frame_handle = '0;
    logic [vfpe_pkg::FBITS_W-1:0]     frame_bits = '0;
    logic                             tagged_req = 1'b0;
    logic [vfpe_pkg::VID_W-1:0]       vid = '0;
    logic [vfpe_pkg::PCP_W-1:0]       priority_code = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic [2:0]                       event_res;
    logic                             tx_start;
    logic [vfpe_pkg::HANDLE_W-1:0]    tx_handle;
    logic [vfpe_pkg::FBITS_W-1:0]     tx_bits;
    logic [vfpe_pkg::CLS_W-1:0]       tx_priority;
    logic [vfpe_pkg::VID_W-1:0]       tx_vid;
    logic [vfpe_pkg::TOTAL_OUT_W-1:0] queued_total;
    logic [1:0]                       link_mode;

    vlan_filtered_priority_egress #(
        .CLASS_DEPTH(CLASS_DEPTH),
        .NUM_CLASSES(NUM_CLASSES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .frame_handle(frame_handle),
        .frame_bits(frame_bits),
        .tagged_req(tagged_req),
        .vid(vid),
        .priority_code(priority_code),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .event_res(event_res),
        .tx_start(tx_start),
        .tx_handle(tx_handle),
        .tx_bits(tx_bits),
        .tx_priority(tx_priority),
        .tx_vid(tx_vid),
        .queued_total(queued_total),
        .link_mode(link_mode)
    );

    always #4 clk = ~clk;

    // scheduler shadow state
    logic [vfpe_pkg::RATE_W-1:0] rate_cfg;
    logic [vfpe_pkg::CNT_W-1:0]  count_cfg;
    logic [vfpe_pkg::VID_W-1:0]  vlan_cfg [vfpe_pkg::MAX_VLANS];
    vfpe_pkg::link_t             link_st;
    int unsigned                 bits_left;
    vfpe_pkg::desc_t             desc_mem [NUM_CLASSES*CLASS_DEPTH];
    int unsigned                 head_ptr [NUM_CLASSES];
    int unsigned                 tail_ptr [NUM_CLASSES];
    int unsigned                 class_fill [NUM_CLASSES];

    egress_res_t predicted_events [$];
    dir_row_t    directed_rows [$];

    int  idle_pct = 0;
    int  stall_pct = 0;
    bit  hold_wanted = 1'b0;
    bit  hold_taken = 1'b0;
    int  hold_left = 0;
    int  quiet_cycles = 0;
    int  fail_count = 0;
    int  words_sent = 0;
    int  frames_queued = 0;
    int  frames_started = 0;
    int  full_drops = 0;
    int  vlan_drops = 0;
    int  untag_drops = 0;
    int  settings_used = 0;
    egress_res_t want;

    function automatic int unsigned eff_rate();
        if (rate_cfg == 0) return 1;
        if (rate_cfg > vfpe_pkg::RATE_MAX) return vfpe_pkg::RATE_MAX;
        return rate_cfg;
    endfunction

    function automatic int unsigned list_len();
        return (count_cfg > vfpe_pkg::MAX_VLANS) ? vfpe_pkg::MAX_VLANS : count_cfg;
    endfunction

    function automatic int unsigned frames_waiting();
        int unsigned t;
        t = 0;
        for (int c = 0; c < NUM_CLASSES; c++)
            t += class_fill[c];
        return t;
    endfunction

    function automatic egress_res_t start_next_frame(input egress_res_t r);
        vfpe_pkg::desc_t d;
        for (int c = NUM_CLASSES - 1; c >= 0; c--)
        begin
            if (class_fill[c] != 0)
            begin
                d = desc_mem[c*CLASS_DEPTH + head_ptr[c]];
                head_ptr[c] = (head_ptr[c] + 1) % CLASS_DEPTH;
                class_fill[c]--;
                r.start = 1'b1;
                r.handle = d.handle;
                r.fbits = d.fbits;
                r.pri = vfpe_pkg::CLS_W'(c);
                r.vid = d.vid;
                link_st = vfpe_pkg::LINK_TX;
                bits_left = d.fbits;
                return r;
            end
        end
        link_st = vfpe_pkg::LINK_IDLE;
        bits_left = 0;
        return r;
    endfunction

    function automatic egress_res_t predict_egress(input egress_word_t w);
        egress_res_t r;
        int unsigned rate, cls;
        bit hit;
        r = '0;
        rate = eff_rate();
        if (w.cmd == vfpe_pkg::CMD_TICK)
        begin
            r.ev = vfpe_pkg::EV_TICK;
            if (link_st == vfpe_pkg::LINK_TX)
            begin
                // remainder of a tick past the frame end is dropped
                if (bits_left <= rate)
                begin
                    link_st = vfpe_pkg::LINK_IFG;
                    bits_left = vfpe_pkg::IFG_BITS;
                end
                else
                begin
                    bits_left -= rate;
                end
            end
            else if (link_st == vfpe_pkg::LINK_IFG)
            begin
                if (bits_left <= rate)
                    r = start_next_frame(r);
                else
                    bits_left -= rate;
            end
        end
        else
        begin
            hit = 1'b0;
            for (int i = 0; i < list_len(); i++)
                if (vlan_cfg[i] == w.vid)
                    hit = 1'b1;
            cls = (w.pcp < NUM_CLASSES) ? w.pcp : NUM_CLASSES - 1;
            if (list_len() == 0 || !w.tag_on)
            begin
                r.ev = vfpe_pkg::EV_NO_TAG;
            end
            else if (!hit)
            begin
                r.ev = vfpe_pkg::EV_VLAN_DENY;
            end
            else if (class_fill[cls] >= CLASS_DEPTH)
            begin
                r.ev = vfpe_pkg::EV_CLASS_FULL;
            end
            else
            begin
                desc_mem[cls*CLASS_DEPTH + tail_ptr[cls]] = '{vid: w.vid, fbits: w.fbits,
                                                              handle: w.handle};
                tail_ptr[cls] = (tail_ptr[cls] + 1) % CLASS_DEPTH;
                class_fill[cls]++;
                r.ev = vfpe_pkg::EV_QUEUED;
                if (link_st == vfpe_pkg::LINK_IDLE)
                    r = start_next_frame(r);
            end
        end
        r.total = vfpe_pkg::TOTAL_OUT_W'(frames_waiting());
        r.link = link_st;
        return r;
    endfunction

    function automatic logic [vfpe_pkg::VID_W-1:0] pick_vid();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return vfpe_pkg::VID_W'($urandom);
        endcase
    endfunction

    function automatic egress_word_t tick_word();
        egress_word_t w;
        w.cmd = vfpe_pkg::CMD_TICK;
        w.handle = vfpe_pkg::HANDLE_W'($urandom);
        w.fbits = vfpe_pkg::FBITS_W'($urandom);
        w.tag_on = 1'($urandom);
        w.vid = vfpe_pkg::VID_W'($urandom);
        w.pcp = vfpe_pkg::PCP_W'($urandom);
        return w;
    endfunction

    // listed frames carry a tag and a vid from the current allowed list
    function automatic egress_word_t frame_word(input bit listed,
                                                input logic [vfpe_pkg::PCP_W-1:0] pcp);
        egress_word_t w;
        w = tick_word();
        w.cmd = vfpe_pkg::CMD_FRAME;
        w.pcp = pcp;
        if (listed)
        begin
            w.tag_on = 1'b1;
            w.vid = vlan_cfg[$urandom_range(0, list_len() - 1)];
        end
        else
        begin
            w.vid = pick_vid();
        end
        // keep frames short at slow rates so the queues drain in reasonable time
        if (eff_rate() >= 32 && $urandom_range(0, 15) == 0)
            w.fbits = vfpe_pkg::FBITS_W'($urandom);
        else
            w.fbits = vfpe_pkg::FBITS_W'($urandom_range(0, eff_rate() * 4 + 16));
        return w;
    endfunction

    function automatic void add_row(input egress_word_t w, input bit known,
                                    input egress_res_t res);
        dir_row_t row;
        row.w = w;
        row.known = known;
        row.res = res;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    task automatic send_word(input egress_word_t w, input bit known, input egress_res_t res);
        egress_res_t p;
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= w.cmd;
        frame_handle <= w.handle;
        frame_bits <= w.fbits;
        tagged_req <= w.tag_on;
        vid <= w.vid;
        priority_code <= w.pcp;
        do @(posedge clk); while (!in_ready);
        p = predict_egress(w);
        predicted_events.insert(predicted_events.size(), known ? res : p);
        words_sent++;
        if (p.start) frames_started++;
        case (p.ev)
            vfpe_pkg::EV_QUEUED:     frames_queued++;
            vfpe_pkg::EV_CLASS_FULL: full_drops++;
            vfpe_pkg::EV_VLAN_DENY:  vlan_drops++;
            vfpe_pkg::EV_NO_TAG:     untag_drops++;
            default: ;
        endcase
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (predicted_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [vfpe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [vfpe_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            vfpe_pkg::CFG_BITS_PER_TICK: rate_cfg = data[vfpe_pkg::RATE_W-1:0];
            vfpe_pkg::CFG_ALLOWED_COUNT: count_cfg = data[vfpe_pkg::CNT_W-1:0];
            vfpe_pkg::CFG_VLAN_A:        vlan_cfg[0] = data[vfpe_pkg::VID_W-1:0];
            vfpe_pkg::CFG_VLAN_B:        vlan_cfg[1] = data[vfpe_pkg::VID_W-1:0];
            vfpe_pkg::CFG_VLAN_C:        vlan_cfg[2] = data[vfpe_pkg::VID_W-1:0];
            vfpe_pkg::CFG_VLAN_D:        vlan_cfg[3] = data[vfpe_pkg::VID_W-1:0];
            default: ;
        endcase
    endtask

    // run the link at full rate so the backlog empties in few ticks
    task automatic drain();
        settle();
        write_reg(vfpe_pkg::CFG_BITS_PER_TICK, vfpe_pkg::CFG_DATA_W'(DRAIN_RATE));
        cfg_valid <= 1'b0;
        while (link_st != vfpe_pkg::LINK_IDLE || frames_waiting() != 0)
            send_word(tick_word(), 1'b0, '0);
    endtask

    task automatic configure(input logic [vfpe_pkg::CFG_DATA_W-1:0] rate_word, count_word,
                             input logic [vfpe_pkg::CFG_DATA_W-1:0] va, vb, vc, vd);
        write_reg(vfpe_pkg::CFG_BITS_PER_TICK, rate_word);
        write_reg(vfpe_pkg::CFG_ALLOWED_COUNT, count_word);
        write_reg(vfpe_pkg::CFG_VLAN_A, va);
        write_reg(vfpe_pkg::CFG_VLAN_B, vb);
        write_reg(vfpe_pkg::CFG_VLAN_C, vc);
        write_reg(vfpe_pkg::CFG_VLAN_D, vd);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // result checker and receiver stalls
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (predicted_events.size() == 0)
            begin
                $error("result word with nothing pending");
                fail_count++;
            end
            else
            begin
                want = predicted_events.pop_front();
                if (event_res !== want.ev)
                begin
                    $error("event_res: expected %0d, got %0d", want.ev, event_res);
                    fail_count++;
                end
                if (tx_start !== want.start)
                begin
                    $error("tx_start: expected %0d, got %0d", want.start, tx_start);
                    fail_count++;
                end
                if (tx_handle !== want.handle)
                begin
                    $error("tx_handle: expected %h, got %h", want.handle, tx_handle);
                    fail_count++;
                end
                if (tx_bits !== want.fbits)
                begin
                    $error("tx_bits: expected %0d, got %0d", want.fbits, tx_bits);
                    fail_count++;
                end
                if (tx_priority !== want.pri)
                begin
                    $error("tx_priority: expected %0d, got %0d", want.pri, tx_priority);
                    fail_count++;
                end
                if (tx_vid !== want.vid)
                begin
                    $error("tx_vid: expected %0d, got %0d", want.vid, tx_vid);
                    fail_count++;
                end
                if (queued_total !== want.total)
                begin
                    $error("queued_total: expected %0d, got %0d", want.total, queued_total);
                    fail_count++;
                end
                if (link_mode !== want.link)
                begin
                    $error("link_mode: expected %0d, got %0d", want.link, link_mode);
                    fail_count++;
                end
            end
        end
        if (hold_wanted && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $error("no handshake for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int rate_v, count_v, r;
        logic [vfpe_pkg::PCP_W-1:0] burst_pcp;

        rate_cfg = 1;
        count_cfg = 0;
        foreach (vlan_cfg[i]) vlan_cfg[i] = '0;
        link_st = vfpe_pkg::LINK_IDLE;
        bits_left = 0;
        foreach (head_ptr[c])
        begin
            head_ptr[c] = 0;
            tail_ptr[c] = 0;
            class_fill[c] = 0;
        end

        // reset defaults: empty list rejects even a tagged frame, ticks do nothing
        add_row({vfpe_pkg::CMD_FRAME, 16'h0000, 14'd1, 1'b1, 12'd0, 3'd0}, 1'b1,
                {vfpe_pkg::EV_NO_TAG, 1'b0, 16'h0, 14'd0, 3'd0, 12'd0, 8'd0,
                 vfpe_pkg::LINK_IDLE});
        add_row({vfpe_pkg::CMD_TICK, 16'hFFFF, 14'h3FFF, 1'b1, 12'hFFF, 3'd7}, 1'b1,
                {vfpe_pkg::EV_TICK, 1'b0, 16'h0, 14'd0, 3'd0, 12'd0, 8'd0,
                 vfpe_pkg::LINK_IDLE});
        // list 0, 4095, 100, 200 with an oversized count, rate 64
        add_row({vfpe_pkg::CMD_FRAME, 16'h0001, 14'd10, 1'b0, 12'hFFF, 3'd7}, 1'b1,
                {vfpe_pkg::EV_NO_TAG, 1'b0, 16'h0, 14'd0, 3'd0, 12'd0, 8'd0,
                 vfpe_pkg::LINK_IDLE});
        add_row({vfpe_pkg::CMD_FRAME, 16'h0002, 14'd10, 1'b1, 12'd5, 3'd7}, 1'b1,
                {vfpe_pkg::EV_VLAN_DENY, 1'b0, 16'h0, 14'd0, 3'd0, 12'd0, 8'd0,
                 vfpe_pkg::LINK_IDLE});
        add_row({vfpe_pkg::CMD_FRAME, 16'hFFFF, 14'd64, 1'b1, 12'hFFF, 3'd7}, 1'b1,
                {vfpe_pkg::EV_QUEUED, 1'b1, 16'hFFFF, 14'd64, 3'd7, 12'hFFF, 8'd0,
                 vfpe_pkg::LINK_TX});
        add_row({vfpe_pkg::CMD_FRAME, 16'h0000, 14'd0, 1'b1, 12'd0, 3'd0}, 1'b0, '0);
        add_row({vfpe_pkg::CMD_FRAME, 16'h1234, 14'd65, 1'b1, 12'd100, 3'd3}, 1'b0, '0);
        add_row({vfpe_pkg::CMD_FRAME, 16'h5555, 14'h3FFF, 1'b1, 12'd200, 3'd5}, 1'b0, '0);
        add_row({vfpe_pkg::CMD_FRAME, 16'hAAAA, 14'd1, 1'b1, 12'd100, 3'd5}, 1'b0, '0);
        add_row({vfpe_pkg::CMD_TICK, 16'h0000, 14'd0, 1'b0, 12'd0, 3'd0}, 1'b0, '0);
        add_row({vfpe_pkg::CMD_TICK, 16'h0000, 14'd0, 1'b0, 12'd0, 3'd0}, 1'b0, '0);
        add_row({vfpe_pkg::CMD_TICK, 16'h0000, 14'd0, 1'b0, 12'd0, 3'd0}, 1'b0, '0);
        add_row({vfpe_pkg::CMD_FRAME, 16'h7777, 14'd128, 1'b1, 12'hFFF, 3'd7}, 1'b0, '0);
        add_row({vfpe_pkg::CMD_FRAME, 16'h6666, 14'd100, 1'b1, 12'd200, 3'd6}, 1'b0, '0);
        add_row({vfpe_pkg::CMD_FRAME, 16'h3333, 14'd50, 1'b0, 12'd100, 3'd2}, 1'b0, '0);
        add_row({vfpe_pkg::CMD_FRAME, 16'h4444, 14'd70, 1'b1, 12'd0, 3'd4}, 1'b0, '0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < RESET_ROWS; i++)
            send_word(directed_rows[i].w, directed_rows[i].known, directed_rows[i].res);
        settle();
        configure(12'd64, 12'd7, 12'd0, 12'd4095, 12'd100, 12'd200);
        for (int i = RESET_ROWS; i < directed_rows.size(); i++)
            send_word(directed_rows[i].w, directed_rows[i].known, directed_rows[i].res);
        drain();
        settle();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    rate_v = 1;   count_v = 1;
                end
                1:
                begin
                    rate_v = 0;   count_v = 4;
                end
                2:
                begin
                    rate_v = 127; count_v = 7;
                end
                3:
                begin
                    rate_v = 2;   count_v = 2;
                end
                4:
                begin
                    rate_v = 64;  count_v = 3;
                end
                5:
                begin
                    rate_v = 33;  count_v = 0;
                end
                6:
                begin
                    rate_v = $urandom_range(1, 64); count_v = 5;
                end
                default:
                begin
                    rate_v = $urandom_range(0, 127);
                    count_v = $urandom_range(1, 7);
                end
            endcase
            // unused upper data bits are randomized, the block must ignore them
            configure({5'($urandom), 7'(rate_v)}, {9'($urandom), 3'(count_v)},
                      pick_vid(), pick_vid(), pick_vid(), pick_vid());
            case (p % 4)
                0:
                begin
                    idle_pct = 0;  stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 71; stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;  stall_pct = 71;
                end
                default:
                begin
                    idle_pct = 20; stall_pct = 20;
                end
            endcase
            if (p == PRESSURE_PHASE)
                hold_wanted = 1'b1;
            // a burst into one class runs it past full
            if (list_len() != 0 && p % 2 == 0)
            begin
                burst_pcp = vfpe_pkg::PCP_W'($urandom);
                repeat (BURST_WORDS) send_word(frame_word(1'b1, burst_pcp), 1'b0, '0);
            end
            repeat (WORDS_PER_PHASE)
            begin
                r = $urandom_range(0, 99);
                if (r < 50)
                    send_word(tick_word(), 1'b0, '0);
                else if (r < 88 && list_len() != 0)
                    send_word(frame_word(1'b1, vfpe_pkg::PCP_W'($urandom)), 1'b0, '0);
                else
                    send_word(frame_word(1'b0, vfpe_pkg::PCP_W'($urandom)), 1'b0, '0);
            end
            drain();
            settle();
        end

        $display("run covered %0d words over %0d register settings", words_sent, settings_used);
        $display("frames: %0d queued, %0d started, %0d class full, %0d vlan denied, %0d no tag",
                 frames_queued, frames_started, full_drops, vlan_drops, untag_drops);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
